FILE: hdl/psc_pkg.sv
package psc_pkg;

  // coordinate format
  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 16;
  localparam int MUL_W      = COORD_BITS + 2;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int MIN_W      = 2 * COORD_BITS + 3;
  localparam int DEN_W      = 2 * COORD_BITS + 2;
  localparam int ROOT_W     = COORD_BITS + 2;
  localparam int OUT_W      = COORD_BITS + 2;
  localparam int T_W        = FRAC_BITS + 1;
  localparam int DIV_CNT_W  = $clog2(FRAC_BITS);
  localparam int ROOT_CNT_W = $clog2(ROOT_W);
  localparam int ADDR_W     = 4;

  // register map indexes
  localparam logic [1:0] REG_OBS_X  = 2'd0;
  localparam logic [1:0] REG_OBS_Y  = 2'd1;
  localparam logic [1:0] REG_OBS_Z  = 2'd2;
  localparam logic [1:0] REG_RADIUS = 2'd3;

  // reset values of the registers
  localparam logic [COORD_BITS-1:0] OBS_X_RST  = COORD_BITS'(32768);
  localparam logic [COORD_BITS-1:0] OBS_Y_RST  = COORD_BITS'(39322);
  localparam logic [COORD_BITS-1:0] OBS_Z_RST  = '0;
  localparam logic [COORD_BITS-2:0] RADIUS_RST = (COORD_BITS-1)'(19661);

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_PT   = 9'b000000010,
    ST_DEN  = 9'b000000100,
    ST_DOT  = 9'b000001000,
    ST_DIV  = 9'b000010000,
    ST_TU   = 9'b000100000,
    ST_SEG  = 9'b001000000,
    ST_SQRT = 9'b010000000,
    ST_OUT  = 9'b100000000
  } state_t;

  typedef struct packed {
    logic start;
    logic done;
  } sqrt_ctl_t;

endpackage

FILE: hdl/psc_isqrt.sv
module psc_isqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [psc_pkg::MIN_W-1:0]  value,
  output logic                       done,
  output logic [psc_pkg::ROOT_W-1:0] root
);
  import psc_pkg::*;

  logic [MIN_W-1:0]      n_r, n_nxt;
  logic [MIN_W-1:0]      res_r, res_nxt;
  logic [MIN_W-1:0]      bit_r, bit_nxt;
  logic [ROOT_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [MIN_W:0]        trial;

  // one result bit per cycle, digit by digit
  always_comb begin
    trial    = {1'b0, res_r} + {1'b0, bit_r};
    n_nxt    = n_r;
    res_nxt  = res_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      n_nxt    = value;
      res_nxt  = '0;
      bit_nxt  = MIN_W'(1) << (2 * (ROOT_W - 1));
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if ({1'b0, n_r} >= trial) begin
        n_nxt   = n_r - trial[MIN_W-1:0];
        res_nxt = (res_r >> 1) + bit_r;
      end else begin
        res_nxt = res_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ROOT_CNT_W'(ROOT_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    res_r <= res_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end

  assign done = done_r;
  assign root = res_r[ROOT_W-1:0];

endmodule

FILE: hdl/polyline_sphere_clearance_unit.sv
// Polyline clearance against a spherical obstacle.
// Input channel (in_valid/in_ready): one waypoint per beat, signed fixed point
// coordinates, plus a first flag that starts a new path. Result channel
// (out_valid/out_ready): one beat per waypoint with the running clearance,
// floor(sqrt(min squared distance)) minus the safe radius, and a collision-free
// flag. The obstacle center and safe radius sit in APB registers at 0x0, 0x4,
// 0x8 and 0xC; write them only while the block is idle.
// A waypoint keeps in_ready low while it is processed: three multiply-accumulates
// each for the point distance, segment length and dot product, 16 divide steps
// for the projection when it needs the divide, six for the closest point, 26
// square root steps, then finishing the root and loading the result.
// Without a segment only the point distance and the root are done; a repeated
// waypoint skips the projection, and a clamped one skips the divide. The result
// beat appears in the cycle in_ready returns high. All of it runs on one shared
// multiplier and one square root unit.
// The output register holds a result while out_ready is low; the next
// waypoint may be accepted then, but its result waits for the register.
// Reset clears the path state and returns the registers to their defaults.
module polyline_sphere_clearance_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic signed [psc_pkg::COORD_BITS-1:0] in_point_x,
  input  logic signed [psc_pkg::COORD_BITS-1:0] in_point_y,
  input  logic signed [psc_pkg::COORD_BITS-1:0] in_point_z,
  input  logic                               in_first,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [psc_pkg::OUT_W-1:0]   out_clearance,
  output logic                               out_collision_free,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [psc_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready
);
  import psc_pkg::*;

  state_t state_r, state_nxt;

  logic [COORD_BITS-1:0] obs_x_r, obs_y_r, obs_z_r;
  logic [COORD_BITS-2:0] radius_r;
  logic signed [COORD_BITS-1:0] prev_x_r, prev_y_r, prev_z_r;
  logic signed [COORD_BITS-1:0] q_x_r, q_y_r, q_z_r;
  logic have_prev_r, have_prev_nxt;
  logic [MIN_W-1:0] min_r, min_nxt;
  logic signed [PROD_W-1:0] acc_r, acc_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [T_W-1:0] t_r, t_nxt;
  logic signed [PROD_W-1:0] tu_r, tu_nxt;
  logic [1:0] ax_r, ax_nxt;
  logic [DIV_CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0] clr_r, clr_nxt;
  logic cfree_r, cfree_nxt;

  logic in_acc;
  logic cfg_wr;
  logic signed [MUL_W-1:0] sel_q, sel_p, sel_o;
  logic signed [MUL_W-1:0] u_ax, v_ax, d_pt, c_ax, d_seg;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [PROD_W-1:0] prod, acc_fin;
  logic [DEN_W:0] rem_dbl;
  logic signed [OUT_W:0] clr_full;
  logic sq_start;
  logic sq_done;
  logic [ROOT_W-1:0] root;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;

  // register read back
  always_comb begin
    case (paddr[3:2])
      REG_OBS_X:  prdata = 32'(obs_x_r);
      REG_OBS_Y:  prdata = 32'(obs_y_r);
      REG_OBS_Z:  prdata = 32'(obs_z_r);
      REG_RADIUS: prdata = 32'(radius_r);
      default:    prdata = '0;
    endcase
  end

  // axis selection for the shared multiplier
  always_comb begin
    case (ax_r)
      2'd0: begin
        sel_q = MUL_W'(q_x_r);
        sel_p = MUL_W'(prev_x_r);
        sel_o = MUL_W'($signed(obs_x_r));
      end
      2'd1: begin
        sel_q = MUL_W'(q_y_r);
        sel_p = MUL_W'(prev_y_r);
        sel_o = MUL_W'($signed(obs_y_r));
      end
      default: begin
        sel_q = MUL_W'(q_z_r);
        sel_p = MUL_W'(prev_z_r);
        sel_o = MUL_W'($signed(obs_z_r));
      end
    endcase
    d_pt  = sel_q - sel_o;
    u_ax  = sel_q - sel_p;
    v_ax  = sel_o - sel_p;
    c_ax  = sel_p + MUL_W'(tu_r >>> FRAC_BITS);
    d_seg = sel_o - c_ax;
  end

  // operand mux and the one multiplier
  always_comb begin
    case (state_r)
      ST_DEN: begin
        mul_a = u_ax;
        mul_b = u_ax;
      end
      ST_DOT: begin
        mul_a = u_ax;
        mul_b = v_ax;
      end
      ST_TU: begin
        mul_a = MUL_W'($signed({1'b0, t_r}));
        mul_b = u_ax;
      end
      ST_SEG: begin
        mul_a = d_seg;
        mul_b = d_seg;
      end
      default: begin
        mul_a = d_pt;
        mul_b = d_pt;
      end
    endcase
    prod    = mul_a * mul_b;
    acc_fin = acc_r + prod;
  end

  assign rem_dbl  = {rem_r, 1'b0};
  assign clr_full = $signed({1'b0, root}) - $signed({(OUT_W - COORD_BITS + 2)'(0), radius_r});

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    have_prev_nxt = have_prev_r;
    min_nxt       = min_r;
    acc_nxt       = acc_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    t_nxt         = t_r;
    tu_nxt        = tu_r;
    ax_nxt        = ax_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    clr_nxt       = clr_r;
    cfree_nxt     = cfree_r;
    sq_start      = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_first) begin
            have_prev_nxt = 1'b0;
            min_nxt       = '1;
          end
          acc_nxt   = '0;
          ax_nxt    = '0;
          state_nxt = ST_PT;
        end
      end
      ST_PT: begin
        acc_nxt = acc_fin;
        ax_nxt  = ax_r + 1'b1;
        if (ax_r == 2'd2) begin
          if (acc_fin[MIN_W-1:0] < min_r) begin
            min_nxt = acc_fin[MIN_W-1:0];
          end
          acc_nxt = '0;
          ax_nxt  = '0;
          if (have_prev_r) begin
            state_nxt = ST_DEN;
          end else begin
            state_nxt = ST_SQRT;
          end
        end
      end
      ST_DEN: begin
        acc_nxt = acc_fin;
        ax_nxt  = ax_r + 1'b1;
        if (ax_r == 2'd2) begin
          den_nxt   = acc_fin[DEN_W-1:0];
          acc_nxt   = '0;
          ax_nxt    = '0;
          state_nxt = ST_DOT;
        end
      end
      ST_DOT: begin
        acc_nxt = acc_fin;
        ax_nxt  = ax_r + 1'b1;
        if (ax_r == 2'd2) begin
          acc_nxt     = '0;
          ax_nxt      = '0;
          div_cnt_nxt = '0;
          rem_nxt     = acc_fin[DEN_W-1:0];
          t_nxt       = '0;
          state_nxt   = ST_TU;
          if (den_r == '0) begin
            state_nxt = ST_SQRT;
          end else if (acc_fin[PROD_W-1] || acc_fin == '0) begin
            t_nxt = '0;
          end else if (acc_fin >= $signed({2'b00, den_r})) begin
            t_nxt = T_W'(1) << FRAC_BITS;
          end else begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // restoring division, one quotient bit per cycle
        if (rem_dbl >= {1'b0, den_r}) begin
          rem_nxt = DEN_W'(rem_dbl - {1'b0, den_r});
          t_nxt   = {t_r[T_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_dbl[DEN_W-1:0];
          t_nxt   = {t_r[T_W-2:0], 1'b0};
        end
        div_cnt_nxt = div_cnt_r + 1'b1;
        if (div_cnt_r == DIV_CNT_W'(FRAC_BITS - 1)) begin
          state_nxt = ST_TU;
        end
      end
      ST_TU: begin
        tu_nxt    = prod;
        state_nxt = ST_SEG;
      end
      ST_SEG: begin
        acc_nxt   = acc_fin;
        ax_nxt    = ax_r + 1'b1;
        state_nxt = ST_TU;
        if (ax_r == 2'd2) begin
          if (acc_fin[MIN_W-1:0] < min_r) begin
            min_nxt = acc_fin[MIN_W-1:0];
          end
          ax_nxt    = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        if (sq_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          clr_nxt       = clr_full[OUT_W-1:0];
          cfree_nxt     = !clr_full[OUT_W];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    // root starts on entry to the square root state
    if (state_nxt == ST_SQRT && state_r != ST_SQRT) begin
      sq_start      = 1'b1;
      have_prev_nxt = 1'b1;
    end
  end

  psc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_start),
    .value (min_nxt),
    .done  (sq_done),
    .root  (root)
  );

  // datapath registers
  always_ff @(posedge clk) begin
    acc_r     <= acc_nxt;
    den_r     <= den_nxt;
    rem_r     <= rem_nxt;
    t_r       <= t_nxt;
    tu_r      <= tu_nxt;
    div_cnt_r <= div_cnt_nxt;
    clr_r     <= clr_nxt;
    cfree_r   <= cfree_nxt;
    if (in_acc) begin
      q_x_r <= in_point_x;
      q_y_r <= in_point_y;
      q_z_r <= in_point_z;
    end
  end

  // control, path state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      have_prev_r <= 1'b0;
      min_r       <= '1;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
      prev_x_r    <= '0;
      prev_y_r    <= '0;
      prev_z_r    <= '0;
      obs_x_r     <= OBS_X_RST;
      obs_y_r     <= OBS_Y_RST;
      obs_z_r     <= OBS_Z_RST;
      radius_r    <= RADIUS_RST;
    end else begin
      state_r     <= state_nxt;
      have_prev_r <= have_prev_nxt;
      min_r       <= min_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
      if (sq_start) begin
        prev_x_r <= q_x_r;
        prev_y_r <= q_y_r;
        prev_z_r <= q_z_r;
      end
      if (cfg_wr) begin
        case (paddr[3:2])
          REG_OBS_X:  obs_x_r  <= pwdata[COORD_BITS-1:0];
          REG_OBS_Y:  obs_y_r  <= pwdata[COORD_BITS-1:0];
          REG_OBS_Z:  obs_z_r  <= pwdata[COORD_BITS-1:0];
          REG_RADIUS: radius_r <= pwdata[COORD_BITS-2:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid          = out_valid_r;
  assign out_clearance      = clr_r;
  assign out_collision_free = cfree_r;

endmodule

FILE: hdl/psc_checker.sv
module psc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [psc_pkg::OUT_W-1:0]     out_clearance,
  input logic                          out_collision_free,
  input logic                          pready
);
  import psc_pkg::*;

  // a held result beat keeps its clearance
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_clearance))
    else $error("result beat changed while stalled");

  // flag agrees with the sign of the clearance
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_collision_free == !out_clearance[OUT_W-1])
    else $error("collision flag disagrees with clearance");

  // one waypoint at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second waypoint taken while busy");

  // nothing to deliver after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready dropped");

endmodule

bind polyline_sphere_clearance_unit psc_checker u_psc_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_clearance      (out_clearance),
  .out_collision_free (out_collision_free),
  .pready             (pready)
);

FILE: bench/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import psc_pkg::*;

  localparam int MAX_CYCLES = 2000000;
  localparam int DRAIN_CYCLES = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_BITS-1:0] in_point_x = '0;
  logic signed [COORD_BITS-1:0] in_point_y = '0;
  logic signed [COORD_BITS-1:0] in_point_z = '0;
  logic in_first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OUT_W-1:0] out_clearance;
  logic out_collision_free;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  polyline_sphere_clearance_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_point_x(in_point_x), .in_point_y(in_point_y), .in_point_z(in_point_z),
    .in_first(in_first),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_clearance(out_clearance), .out_collision_free(out_collision_free),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #2 clk = ~clk;

  typedef struct {
    logic signed [OUT_W-1:0] clearance;
    logic collision_free;
  } clearance_t;

  clearance_t clearance_q[$];
  int errors = 0;
  int cycle_count = 0;
  int beats_in = 0;
  int beats_out = 0;
  int hold_off = 0;
  int rx_wait = 0;
  bit random_ready = 1'b0;

  // predictor copy of registers and path state
  longint obs_x, obs_y, obs_z, radius;
  longint last_x, last_y, last_z;
  bit last_valid;
  longint unsigned best_sq;
  localparam longint unsigned BEST_INIT = (64'd1 << MIN_W) - 1;

  function automatic longint unsigned sq_sum(longint dx, longint dy, longint dz);
    return dx * dx + dy * dy + dz * dz;
  endfunction

  function automatic longint floor_frac(longint v);
    return v >>> FRAC_BITS;
  endfunction

  function automatic longint unsigned int_root(longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // expected clearance for one waypoint, updates path state
  function automatic clearance_t predict_clearance(longint qx, longint qy, longint qz,
                                                   bit new_path);
    clearance_t res;
    longint ux, uy, uz, vx, vy, vz, dot, t, cx, cy, cz, clr;
    longint unsigned den, d, rem, quo;
    if (new_path) begin
      last_valid = 1'b0;
      best_sq = BEST_INIT;
    end
    d = sq_sum(qx - obs_x, qy - obs_y, qz - obs_z);
    if (d < best_sq) best_sq = d;
    if (last_valid) begin
      ux = qx - last_x; uy = qy - last_y; uz = qz - last_z;
      vx = obs_x - last_x; vy = obs_y - last_y; vz = obs_z - last_z;
      den = sq_sum(ux, uy, uz);
      if (den != 0) begin
        dot = ux * vx + uy * vy + uz * vz;
        if (dot <= 0) t = 0;
        else if (longint'(unsigned'(dot)) >= 0 && unsigned'(dot) >= den) t = 1 << FRAC_BITS;
        else begin
          rem = dot;
          quo = 0;
          for (int i = 0; i < FRAC_BITS; i++) begin
            rem <<= 1;
            quo <<= 1;
            if (rem >= den) begin
              rem -= den;
              quo |= 1;
            end
          end
          t = quo;
        end
        cx = last_x + floor_frac(t * ux);
        cy = last_y + floor_frac(t * uy);
        cz = last_z + floor_frac(t * uz);
        d = sq_sum(obs_x - cx, obs_y - cy, obs_z - cz);
        if (d < best_sq) best_sq = d;
      end
    end
    last_x = qx; last_y = qy; last_z = qz;
    last_valid = 1'b1;
    clr = longint'(int_root(best_sq)) - radius;
    res.clearance = clr[OUT_W-1:0];
    res.collision_free = (clr >= 0);
    return res;
  endfunction

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("tb failed");
      $finish;
    end
  end

  // receiver: a drawn wait per beat or a long hold-off
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (random_ready) begin
      if (out_valid && out_ready) begin
        draw = $urandom_range(0, 10);
        rx_wait <= draw;
        out_ready <= (draw == 0);
      end else if (rx_wait > 0) begin
        rx_wait <= rx_wait - 1;
        out_ready <= (rx_wait == 1);
      end else begin
        out_ready <= 1'b1;
      end
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    clearance_t exp_res;
    if (rst_n && out_valid && out_ready) begin
      beats_out++;
      if (clearance_q.size() == 0) begin
        $error("result beat with no expectation waiting");
        errors++;
      end else begin
        exp_res = clearance_q.pop_front();
        if (out_clearance !== exp_res.clearance) begin
          $error("clearance: expected %0d, actual %0d", exp_res.clearance, out_clearance);
          errors++;
        end
        if (out_collision_free !== exp_res.collision_free) begin
          $error("collision_free: expected %0d, actual %0d", exp_res.collision_free,
                 out_collision_free);
          errors++;
        end
      end
    end
  end

  // valid stays up after a beat so the next one can follow directly
  task automatic send_point(longint x, longint y, longint z, bit new_path, bit gap);
    int wait_cycles;
    clearance_t exp_res;
    wait_cycles = gap ? $urandom_range(0, 10) : 0;
    if (wait_cycles > 0) begin
      in_valid <= 1'b0;
      repeat (wait_cycles) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_point_x <= x[COORD_BITS-1:0];
    in_point_y <= y[COORD_BITS-1:0];
    in_point_z <= z[COORD_BITS-1:0];
    in_first <= new_path;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    exp_res = predict_clearance(
      longint'(in_point_x), longint'(in_point_y), longint'(in_point_z), new_path);
    clearance_q.insert(clearance_q.size(), exp_res);
    beats_in++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (clearance_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, longint value);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value[31:0];
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_OBS_X: obs_x = longint'(signed'(value[COORD_BITS-1:0]));
      REG_OBS_Y: obs_y = longint'(signed'(value[COORD_BITS-1:0]));
      REG_OBS_Z: obs_z = longint'(signed'(value[COORD_BITS-1:0]));
      default:   radius = value[COORD_BITS-2:0];
    endcase
  endtask

  function automatic longint rand_coord(int span);
    if (span >= COORD_BITS) return longint'(signed'(COORD_BITS'($urandom)));
    return longint'($urandom_range(0, (1 << span) - 1)) - (1 << (span - 1));
  endfunction

  task automatic set_obstacle(longint x, longint y, longint z, longint r);
    write_reg(REG_OBS_X, x);
    write_reg(REG_OBS_Y, y);
    write_reg(REG_OBS_Z, z);
    write_reg(REG_RADIUS, r);
  endtask

  // field extremes, repeated points, new paths with default and extreme registers
  task automatic test_directed();
    longint mx, mn;
    mx = (1 << (COORD_BITS - 1)) - 1;
    mn = -(1 << (COORD_BITS - 1));
    send_point(0, 0, 0, 1'b0, 1'b0);
    send_point(65536, 0, 0, 1'b0, 1'b0);
    send_point(65536, 0, 0, 1'b0, 1'b0);
    send_point(0, 65536, 0, 1'b0, 1'b1);
    send_point(mx, mx, mx, 1'b1, 1'b1);
    send_point(mn, mn, mn, 1'b0, 1'b0);
    send_point(mx, mn, mx, 1'b0, 1'b0);
    send_point(mn, mx, mn, 1'b0, 1'b1);
    send_point(32768, 39322, 0, 1'b1, 1'b0);
    send_point(-65536, 39322, 0, 1'b1, 1'b0);
    send_point(131072, 39322, 0, 1'b0, 1'b0);
    send_point(131072, 39322, 0, 1'b0, 1'b0);
    send_point(-1, -1, -1, 1'b0, 1'b1);
    drain();
    set_obstacle(mx, mn, mx, (1 << (COORD_BITS - 1)) - 1);
    send_point(mn, mx, mn, 1'b1, 1'b0);
    send_point(mx, mn, mx - 5, 1'b0, 1'b0);
    send_point(mx, mx, mx, 1'b0, 1'b0);
    drain();
    set_obstacle(mn, mx, mn, 0);
    send_point(mx, mn, mx, 1'b1, 1'b0);
    send_point(mn, mx, mn, 1'b0, 1'b0);
    send_point(0, 0, 0, 1'b0, 1'b0);
    drain();
  endtask

  // random paths, mostly short and small, some full range
  task automatic test_random_paths(int count, bit gaps);
    int span, left;
    longint r;
    left = 0;
    span = 18;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        left = $urandom_range(1, 12);
        span = ($urandom_range(0, 4) == 0) ? COORD_BITS : $urandom_range(4, 20);
        send_point(rand_coord(span), rand_coord(span), rand_coord(span),
                   $urandom_range(0, 7) != 0, gaps && ($urandom_range(0, 2) != 0));
      end else begin
        r = $urandom_range(0, 15);
        if (r == 0)
          send_point(longint'(in_point_x), longint'(in_point_y), longint'(in_point_z),
                     1'b0, gaps);
        else
          send_point(rand_coord(span), rand_coord(span), rand_coord(span), 1'b0,
                     gaps && ($urandom_range(0, 2) != 0));
      end
      left--;
    end
  endtask

  // receiver stalls for a long stretch while waypoints keep coming
  task automatic test_backpressure();
    hold_off = 600;
    test_random_paths(20, 1'b0);
    drain();
  endtask

  task automatic test_register_sweep();
    for (int k = 0; k < 6; k++) begin
      set_obstacle(rand_coord(k < 3 ? 18 : COORD_BITS), rand_coord(18),
                   rand_coord(k < 3 ? 18 : COORD_BITS),
                   $urandom_range(0, (1 << (COORD_BITS - 1)) - 1) >> $urandom_range(0, 20));
      random_ready = (k % 2 == 0);
      test_random_paths(250, k != 5);
      drain();
    end
  endtask

  initial begin
    obs_x = 32768; obs_y = 39322; obs_z = 0; radius = 19661;
    last_x = 0; last_y = 0; last_z = 0; last_valid = 1'b0;
    best_sq = BEST_INIT;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    random_ready = 1'b1;
    test_backpressure();
    test_register_sweep();
    drain();
    $display("covered %0d waypoints and %0d result beats over extreme, random and",
             beats_in, beats_out);
    $display("stalled runs with several obstacle and radius settings");
    if (errors == 0 && clearance_q.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule

FILE: sim.f
hdl/psc_pkg.sv
hdl/psc_isqrt.sv
hdl/polyline_sphere_clearance_unit.sv
hdl/psc_checker.sv
bench/tb.sv
